>>> sv/water_ripple_grid_macros.svh
// assertion macros used by the ripple grid top level
`ifndef WATER_RIPPLE_GRID_MACROS_SVH
`define WATER_RIPPLE_GRID_MACROS_SVH

`ifndef ASSERT_OFF

// property checked on every clock edge outside reset
`define WRG_ASSERT(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// condition on one edge implies a condition on the next edge
`define WRG_ASSERT_NEXT(name, clk, rst, pre, post, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`else

`define WRG_ASSERT(name, clk, rst, prop, msg)
`define WRG_ASSERT_NEXT(name, clk, rst, pre, post, msg)

`endif

`endif

>>> sv/wrg_pkg.sv
`default_nettype none

package wrg_pkg;

   // grid geometry
   localparam int GRID_WIDTH  = 16;
   localparam int GRID_HEIGHT = 9;
   localparam int KEY_COUNT   = 144;
   localparam int CELLS       = GRID_WIDTH * GRID_HEIGHT;
   localparam int MAP_SIZE    = 144;

   localparam int CELL_W = $clog2(CELLS);
   localparam int COL_W  = $clog2(GRID_WIDTH);
   localparam int ROW_W  = $clog2(GRID_HEIGHT);
   localparam int MAP_W  = $clog2(MAP_SIZE);

   // command codes
   localparam logic [1:0] CMD_KEY  = 2'd0;
   localparam logic [1:0] CMD_DROP = 2'd1;
   localparam logic [1:0] CMD_TICK = 2'd2;
   localparam logic [1:0] CMD_READ = 2'd3;

   // register indexes
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_RAINBOW_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FIXED_HUE    = 1'd1;

   // heights written by keys and drops
   localparam logic [7:0] HEIGHT_PEAK   = 8'h7f;
   localparam logic [7:0] HEIGHT_SPLASH = 8'h60;

   // key position to grid cell
   localparam logic [7:0] KEY_MAP [MAP_SIZE] = '{
      8'd71,  8'd71,  8'd72,  8'd73,  8'd74,  8'd75,  8'd76,  8'd76,  8'd76,
      8'd107, 8'd107, 8'd106, 8'd105, 8'd104, 8'd103, 8'd102, 8'd101, 8'd101,
      8'd70,  8'd0,   8'd1,   8'd2,   8'd3,   8'd4,   8'd5,   8'd6,   8'd77,
      8'd108, 8'd33,  8'd34,  8'd35,  8'd36,  8'd37,  8'd38,  8'd39,  8'd100,
      8'd69,  8'd7,   8'd8,   8'd9,   8'd10,  8'd11,  8'd12,  8'd78,  8'd109,
      8'd47,  8'd46,  8'd45,  8'd44,  8'd43,  8'd42,  8'd41,  8'd40,  8'd99,
      8'd98,  8'd13,  8'd14,  8'd15,  8'd16,  8'd17,  8'd18,  8'd79,  8'd110,
      8'd54,  8'd53,  8'd52,  8'd51,  8'd50,  8'd49,  8'd48,  8'd130, 8'd130,
      8'd97,  8'd19,  8'd20,  8'd21,  8'd22,  8'd23,  8'd24,  8'd25,  8'd80,
      8'd111, 8'd60,  8'd59,  8'd58,  8'd57,  8'd56,  8'd55,  8'd129, 8'd129,
      8'd96,  8'd26,  8'd27,  8'd28,  8'd29,  8'd30,  8'd31,  8'd32,  8'd81,
      8'd112, 8'd68,  8'd67,  8'd66,  8'd65,  8'd64,  8'd63,  8'd62,  8'd61,
      8'd95,  8'd94,  8'd93,  8'd92,  8'd86,  8'd85,  8'd84,  8'd83,  8'd82,
      8'd113, 8'd114, 8'd115, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127, 8'd128,
      8'd91,  8'd90,  8'd89,  8'd88,  8'd87,  8'd86,  8'd85,  8'd84,  8'd83,
      8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120, 8'd121, 8'd122
   };

   typedef logic [CELL_W-1:0] cell_addr_type;

   // one page memory access
   typedef struct packed {
      logic          wr_en;
      cell_addr_type wr_addr;
      logic [7:0]    wr_data;
      logic          rd_en;
      cell_addr_type rd_addr;
   } ram_port_type;

   // ripple sequencer requests on the current and the next page
   typedef struct packed {
      ram_port_type cur;
      ram_port_type nxt;
      logic         done;
   } rip_ctl_type;

   // colour of one cell
   typedef struct packed {
      logic [7:0]        hue;
      logic [7:0]        saturation;
      logic [7:0]        brightness;
      logic signed [7:0] height;
   } shade_type;

   function automatic cell_addr_type cell_addr(input logic [ROW_W-1:0] row,
                                               input logic [COL_W-1:0] col);
      return CELL_W'(int'(row) * GRID_WIDTH + int'(col));
   endfunction

endpackage

`default_nettype wire

>>> sv/wrg_ram.sv
`default_nettype none

module wrg_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 144
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds when not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> sv/wrg_ripple.sv
`default_nettype none

module wrg_ripple (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [7:0]           cur_q,
   input  logic [7:0]           nxt_q,
   output wrg_pkg::rip_ctl_type ctl
);

   localparam logic [3:0] STEP_FIRST_DATA = 4'd1;
   localparam logic [3:0] STEP_LAST_TAP   = 4'd7;
   localparam logic [3:0] STEP_WRITE      = 4'd8;

   logic                        active_ff, active_in;
   logic [3:0]                  step_ff, step_in;
   logic [wrg_pkg::COL_W-1:0]   x_ff, x_in;
   logic [wrg_pkg::ROW_W-1:0]   y_ff, y_in;
   logic signed [10:0]          acc_ff, acc_in;
   logic [7:0]                  other_ff, other_in;

   logic [wrg_pkg::ROW_W-1:0]   up_row, dn_row, tap_row;
   logic [wrg_pkg::COL_W-1:0]   lf_col, rt_col, tap_col;
   logic                        last_x, last_y;
   wrg_pkg::cell_addr_type      idx;
   logic signed [7:0]           tap_s, other_s;
   logic signed [10:0]          total;
   logic signed [8:0]           quarter;
   logic signed [9:0]           diff;
   logic signed [9:0]           damped;

   // neighbour rows and columns, edge taps moved onto the cell's own line
   always_comb begin
      up_row = (y_ff == '0) ? y_ff : y_ff - wrg_pkg::ROW_W'(1);
      dn_row = last_y ? y_ff : y_ff + wrg_pkg::ROW_W'(1);
      lf_col = (x_ff == '0) ? x_ff : x_ff - wrg_pkg::COL_W'(1);
      rt_col = last_x ? x_ff : x_ff + wrg_pkg::COL_W'(1);
   end

   assign last_x = (x_ff == wrg_pkg::COL_W'(wrg_pkg::GRID_WIDTH - 1));
   assign last_y = (y_ff == wrg_pkg::ROW_W'(wrg_pkg::GRID_HEIGHT - 1));
   assign idx    = wrg_pkg::cell_addr(y_ff, x_ff);

   // tap chosen by the step
   always_comb begin
      case (step_ff[2:0])
         3'd0: begin
            tap_row = up_row;
            tap_col = x_ff;
         end
         3'd1: begin
            tap_row = dn_row;
            tap_col = x_ff;
         end
         3'd2: begin
            tap_row = y_ff;
            tap_col = lf_col;
         end
         3'd3: begin
            tap_row = y_ff;
            tap_col = rt_col;
         end
         3'd4: begin
            tap_row = up_row;
            tap_col = lf_col;
         end
         3'd5: begin
            tap_row = up_row;
            tap_col = rt_col;
         end
         3'd6: begin
            tap_row = dn_row;
            tap_col = lf_col;
         end
         default: begin
            tap_row = dn_row;
            tap_col = rt_col;
         end
      endcase
   end

   // damped update of one cell
   always_comb begin
      tap_s   = cur_q;
      other_s = other_ff;
      total   = acc_ff + 11'(tap_s);
      quarter = 9'(total >>> 2);
      diff    = 10'(quarter) - 10'(other_s);
      damped  = diff - (diff >>> 3);
   end

   // memory requests
   always_comb begin
      ctl = '0;
      if (active_ff) begin
         if (step_ff <= STEP_LAST_TAP) begin
            ctl.cur.rd_en   = 1'b1;
            ctl.cur.rd_addr = wrg_pkg::cell_addr(tap_row, tap_col);
         end
         if (step_ff == '0) begin
            ctl.nxt.rd_en   = 1'b1;
            ctl.nxt.rd_addr = idx;
         end
         if (step_ff == STEP_WRITE) begin
            ctl.nxt.wr_en   = 1'b1;
            ctl.nxt.wr_addr = idx;
            ctl.nxt.wr_data = damped[7:0];
            ctl.done        = last_x && last_y;
         end
      end
   end

   // sequencer over cells and taps
   always_comb begin
      active_in = active_ff;
      step_in   = step_ff;
      x_in      = x_ff;
      y_in      = y_ff;
      if (start) begin
         active_in = 1'b1;
         step_in   = '0;
         x_in      = '0;
         y_in      = '0;
      end else if (active_ff) begin
         if (step_ff == STEP_WRITE) begin
            step_in = '0;
            if (last_x) begin
               x_in = '0;
               if (last_y) begin
                  active_in = 1'b0;
               end else begin
                  y_in = y_ff + wrg_pkg::ROW_W'(1);
               end
            end else begin
               x_in = x_ff + wrg_pkg::COL_W'(1);
            end
         end else begin
            step_in = step_ff + 4'd1;
         end
      end
   end

   // tap accumulation and old value capture
   always_comb begin
      acc_in   = acc_ff;
      other_in = other_ff;
      if (active_ff && step_ff == STEP_FIRST_DATA) begin
         acc_in   = 11'(tap_s);
         other_in = nxt_q;
      end else if (active_ff && step_ff > STEP_FIRST_DATA && step_ff <= STEP_LAST_TAP) begin
         acc_in = total;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         step_ff   <= '0;
         x_ff      <= '0;
         y_ff      <= '0;
      end else begin
         active_ff <= active_in;
         step_ff   <= step_in;
         x_ff      <= x_in;
         y_ff      <= y_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      other_ff <= other_in;
   end

endmodule

`default_nettype wire

>>> sv/wrg_shade.sv
`default_nettype none

module wrg_shade (
   input  logic               [7:0] cur_q,
   input  logic               [7:0] oth_q,
   input  logic                     odd,
   input  logic               [7:0] hue_count,
   input  logic                     rainbow,
   input  logic               [7:0] fixed_hue,
   output wrg_pkg::shade_type       shade
);

   logic signed [7:0] cur_s, oth_s, h;
   logic signed [8:0] pair_sum, avg, h_wide, mag;
   logic [7:0]        inten;

   // height, averaged with the other page on odd frames
   always_comb begin
      cur_s    = cur_q;
      oth_s    = oth_q;
      pair_sum = 9'(cur_s) + 9'(oth_s);
      avg      = pair_sum >>> 1;
      h        = odd ? avg[7:0] : cur_s;
   end

   // intensity from twice the magnitude, kept to 8 bits
   always_comb begin
      h_wide = 9'(h);
      mag    = h[7] ? -h_wide : h_wide;
      inten  = {mag[6:0], 1'b0};
   end

   // colour fields
   always_comb begin
      shade.height     = h;
      shade.saturation = 8'hff - inten;
      shade.brightness = inten[7] ? 8'hff : {inten[6:0], 1'b0};
      if (rainbow) begin
         shade.hue = hue_count + 8'(h) + 8'(h >>> 1);
      end else begin
         shade.hue = fixed_hue;
      end
   end

endmodule

`default_nettype wire

>>> sv/water_ripple_grid.sv
// channel   direction  handshake             payload
// req       in         req_valid/req_stall   cmd, key_address, col, row, cell_req, odd_frame
// rsp       out        rsp_valid/rsp_stall   hue, saturation, brightness, height
// csr       in         csr_valid/csr_ready   csr_index, csr_wdata
//
// key press, read and odd frame tick complete in the idle state; a read result passes through
// the memory read register and then the result register.
// raindrop writes the centre, then the four neighbours: they share the single page write port.
// even frame tick runs a ripple pass: eight taps per cell through one read port.
// after reset a clearing pass writes both pages cell by cell with req_stall high; csr writes
// are taken throughout.
// a waiting result that cannot move to the result register stalls every request.
`default_nettype none
`include "water_ripple_grid_macros.svh"

module water_ripple_grid (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [1:0]                       req_cmd,
   input  logic [7:0]                       req_key_address,
   input  logic [3:0]                       req_col,
   input  logic [3:0]                       req_row,
   input  logic [7:0]                       req_cell_req,
   input  logic                             req_odd_frame,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [7:0]                       rsp_hue,
   output logic [7:0]                       rsp_saturation,
   output logic [7:0]                       rsp_brightness,
   output logic signed [7:0]                rsp_height,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [wrg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [7:0]                       csr_wdata
);

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_DROP   = 2'd2;
   localparam logic [1:0] ST_RIPPLE = 2'd3;

   localparam logic [1:0] NB_UP    = 2'd0;
   localparam logic [1:0] NB_DOWN  = 2'd1;
   localparam logic [1:0] NB_LEFT  = 2'd2;
   localparam logic [1:0] NB_RIGHT = 2'd3;

   logic [1:0]                  state_ff, state_in;
   wrg_pkg::cell_addr_type      clr_ff, clr_in;
   logic [1:0]                  nb_ff, nb_in;
   logic [wrg_pkg::ROW_W-1:0]   drop_row_ff, drop_row_in;
   logic [wrg_pkg::COL_W-1:0]   drop_col_ff, drop_col_in;
   logic                        page_ff, page_in;
   logic [7:0]                  hue_ff, hue_in;
   logic                        rainbow_ff, rainbow_in;
   logic [7:0]                  fixed_hue_ff, fixed_hue_in;
   logic                        rd_pend_ff, rd_pend_in;
   logic                        rd_odd_ff, rd_odd_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   wrg_pkg::shade_type          rsp_data_ff;

   logic                        req_accept, out_free, load_rsp;
   logic [7:0]                  key_pos;
   logic                        key_ok, drop_ok, read_ok, ripple_start;
   logic                        nb_ok;
   logic [wrg_pkg::ROW_W-1:0]   nb_row;
   logic [wrg_pkg::COL_W-1:0]   nb_col;
   wrg_pkg::ram_port_type       cur_port, nxt_port, page0_port, page1_port;
   logic [7:0]                  page0_q, page1_q, cur_q, nxt_q;
   wrg_pkg::rip_ctl_type        rip_ctl;
   wrg_pkg::shade_type          shade;

   // handshakes
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = (state_ff != ST_IDLE) || (rd_pend_ff && !out_free);
   assign req_accept = req_valid && !req_stall;
   assign load_rsp   = rd_pend_ff && out_free;
   assign csr_ready  = 1'b1;

   // command decode
   always_comb begin
      key_pos = wrg_pkg::KEY_MAP[req_key_address[wrg_pkg::MAP_W-1:0]];
      key_ok  = (int'(req_key_address) < wrg_pkg::KEY_COUNT)
             && (int'(req_key_address) < wrg_pkg::MAP_SIZE)
             && (int'(key_pos) < wrg_pkg::CELLS);
      drop_ok = (int'(req_col) < wrg_pkg::GRID_WIDTH)
             && (int'(req_row) < wrg_pkg::GRID_HEIGHT);
      read_ok = int'(req_cell_req) < wrg_pkg::CELLS;
      ripple_start = (state_ff == ST_IDLE) && req_accept
                  && (req_cmd == wrg_pkg::CMD_TICK) && !req_odd_frame;
   end

   // raindrop neighbour for this cycle
   always_comb begin
      nb_row = drop_row_ff;
      nb_col = drop_col_ff;
      case (nb_ff)
         NB_UP: begin
            nb_ok  = drop_row_ff != '0;
            nb_row = drop_row_ff - wrg_pkg::ROW_W'(1);
         end
         NB_DOWN: begin
            nb_ok  = drop_row_ff != wrg_pkg::ROW_W'(wrg_pkg::GRID_HEIGHT - 1);
            nb_row = drop_row_ff + wrg_pkg::ROW_W'(1);
         end
         NB_LEFT: begin
            nb_ok  = drop_col_ff != '0;
            nb_col = drop_col_ff - wrg_pkg::COL_W'(1);
         end
         default: begin
            nb_ok  = drop_col_ff != wrg_pkg::COL_W'(wrg_pkg::GRID_WIDTH - 1);
            nb_col = drop_col_ff + wrg_pkg::COL_W'(1);
         end
      endcase
   end

   // access to the current and the next page
   always_comb begin
      cur_port = '0;
      nxt_port = '0;
      case (state_ff)
         ST_CLEAR: begin
            cur_port.wr_en   = 1'b1;
            cur_port.wr_addr = clr_ff;
            nxt_port.wr_en   = 1'b1;
            nxt_port.wr_addr = clr_ff;
         end
         ST_IDLE: begin
            if (req_accept) begin
               case (req_cmd)
                  wrg_pkg::CMD_KEY: begin
                     cur_port.wr_en   = key_ok;
                     cur_port.wr_addr = wrg_pkg::CELL_W'(key_pos);
                     cur_port.wr_data = wrg_pkg::HEIGHT_PEAK;
                  end
                  wrg_pkg::CMD_DROP: begin
                     cur_port.wr_en   = drop_ok;
                     cur_port.wr_addr = wrg_pkg::cell_addr(wrg_pkg::ROW_W'(req_row),
                                                           wrg_pkg::COL_W'(req_col));
                     cur_port.wr_data = wrg_pkg::HEIGHT_PEAK;
                  end
                  wrg_pkg::CMD_READ: begin
                     cur_port.rd_en   = read_ok;
                     cur_port.rd_addr = wrg_pkg::CELL_W'(req_cell_req);
                     nxt_port.rd_en   = read_ok;
                     nxt_port.rd_addr = wrg_pkg::CELL_W'(req_cell_req);
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_DROP: begin
            cur_port.wr_en   = nb_ok;
            cur_port.wr_addr = wrg_pkg::cell_addr(nb_row, nb_col);
            cur_port.wr_data = wrg_pkg::HEIGHT_SPLASH;
         end
         default: begin
            cur_port = rip_ctl.cur;
            nxt_port = rip_ctl.nxt;
         end
      endcase
   end

   // page select steers current and next onto the two memories
   assign page0_port = page_ff ? nxt_port : cur_port;
   assign page1_port = page_ff ? cur_port : nxt_port;
   assign cur_q      = page_ff ? page1_q : page0_q;
   assign nxt_q      = page_ff ? page0_q : page1_q;

   wrg_ram #(
      .WIDTH (8),
      .DEPTH (wrg_pkg::CELLS)
   ) u_page0 (
      .clock   (clock),
      .wr_en   (page0_port.wr_en),
      .wr_addr (page0_port.wr_addr),
      .wr_data (page0_port.wr_data),
      .rd_en   (page0_port.rd_en),
      .rd_addr (page0_port.rd_addr),
      .rd_data (page0_q)
   );

   wrg_ram #(
      .WIDTH (8),
      .DEPTH (wrg_pkg::CELLS)
   ) u_page1 (
      .clock   (clock),
      .wr_en   (page1_port.wr_en),
      .wr_addr (page1_port.wr_addr),
      .wr_data (page1_port.wr_data),
      .rd_en   (page1_port.rd_en),
      .rd_addr (page1_port.rd_addr),
      .rd_data (page1_q)
   );

   wrg_ripple u_ripple (
      .clock (clock),
      .reset (reset),
      .start (ripple_start),
      .cur_q (cur_q),
      .nxt_q (nxt_q),
      .ctl   (rip_ctl)
   );

   wrg_shade u_shade (
      .cur_q     (cur_q),
      .oth_q     (nxt_q),
      .odd       (rd_odd_ff),
      .hue_count (hue_ff),
      .rainbow   (rainbow_ff),
      .fixed_hue (fixed_hue_ff),
      .shade     (shade)
   );

   // control sequencer
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      nb_in       = nb_ff;
      drop_row_in = drop_row_ff;
      drop_col_in = drop_col_ff;
      page_in     = page_ff;
      hue_in      = hue_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + wrg_pkg::CELL_W'(1);
            if (clr_ff == wrg_pkg::CELL_W'(wrg_pkg::CELLS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_accept && req_cmd == wrg_pkg::CMD_DROP && drop_ok) begin
               state_in    = ST_DROP;
               nb_in       = NB_UP;
               drop_row_in = wrg_pkg::ROW_W'(req_row);
               drop_col_in = wrg_pkg::COL_W'(req_col);
            end
            if (req_accept && req_cmd == wrg_pkg::CMD_TICK) begin
               hue_in = hue_ff + 8'd1;
               if (!req_odd_frame) begin
                  state_in = ST_RIPPLE;
               end
            end
         end
         ST_DROP: begin
            nb_in = nb_ff + 2'd1;
            if (nb_ff == NB_RIGHT) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            if (rip_ctl.done) begin
               state_in = ST_IDLE;
               page_in  = !page_ff;
            end
         end
      endcase
   end

   // read pipeline and result register
   always_comb begin
      rd_pend_in   = rd_pend_ff;
      rd_odd_in    = rd_odd_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load_rsp) begin
         rd_pend_in   = 1'b0;
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (req_accept && req_cmd == wrg_pkg::CMD_READ && read_ok) begin
         rd_pend_in = 1'b1;
         rd_odd_in  = req_odd_frame;
      end
   end

   // configuration writes
   always_comb begin
      rainbow_in   = rainbow_ff;
      fixed_hue_in = fixed_hue_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            wrg_pkg::CSR_RAINBOW_MODE: rainbow_in   = csr_wdata[0];
            wrg_pkg::CSR_FIXED_HUE:    fixed_hue_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         nb_ff        <= NB_UP;
         page_ff      <= 1'b0;
         hue_ff       <= '0;
         rainbow_ff   <= 1'b1;
         fixed_hue_ff <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         nb_ff        <= nb_in;
         page_ff      <= page_in;
         hue_ff       <= hue_in;
         rainbow_ff   <= rainbow_in;
         fixed_hue_ff <= fixed_hue_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      drop_row_ff <= drop_row_in;
      drop_col_ff <= drop_col_in;
      rd_odd_ff   <= rd_odd_in;
      if (load_rsp) begin
         rsp_data_ff <= shade;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hue        = rsp_data_ff.hue;
   assign rsp_saturation = rsp_data_ff.saturation;
   assign rsp_brightness = rsp_data_ff.brightness;
   assign rsp_height     = rsp_data_ff.height;

   // a blocked read keeps its memory output, so no other read may be issued
   `WRG_ASSERT(a_held_read_quiet, clock, reset, (rd_pend_ff && !out_free) |-> (!page0_port.rd_en && !page1_port.rd_en), "memory read issued while a read result is held")

   // a read waiting on a full result register stays pending
   `WRG_ASSERT_NEXT(a_pend_holds, clock, reset, rd_pend_ff && rsp_valid_ff && rsp_stall, rd_pend_ff, "pending read dropped while output is blocked")

   // the last cell of a ripple pass swaps the pages
   `WRG_ASSERT_NEXT(a_ripple_swap, clock, reset, rip_ctl.done, page_ff != $past(page_ff), "ripple pass ended without a page swap")

   // an even frame tick starts the ripple pass
   `WRG_ASSERT_NEXT(a_tick_ripple, clock, reset, ripple_start, state_ff == ST_RIPPLE, "even frame tick did not start the ripple pass")

endmodule

`default_nettype wire

>>> tb/tb_water_ripple_grid.sv
`timescale 1ns / 100ps

module tb_water_ripple_grid;

   // grid geometry and heights as the predictor sees them
   localparam int COLS        = 16;
   localparam int ROWS        = 9;
   localparam int NCELLS      = COLS * ROWS;
   localparam int NKEYS       = 144;
   localparam logic [7:0] PEAK   = 8'h7f;
   localparam logic [7:0] SPLASH = 8'h60;
   localparam int SETTLE_CYCLES  = 1400;
   localparam int ITEMS_PER_PHASE = 185;

   // key position to cell index
   localparam logic [7:0] KEY_CELL [NKEYS] = '{
      8'd71, 8'd71, 8'd72, 8'd73, 8'd74, 8'd75, 8'd76, 8'd76, 8'd76,
      8'd107, 8'd107, 8'd106, 8'd105, 8'd104, 8'd103, 8'd102, 8'd101, 8'd101,
      8'd70, 8'd0, 8'd1, 8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd77,
      8'd108, 8'd33, 8'd34, 8'd35, 8'd36, 8'd37, 8'd38, 8'd39, 8'd100,
      8'd69, 8'd7, 8'd8, 8'd9, 8'd10, 8'd11, 8'd12, 8'd78, 8'd109,
      8'd47, 8'd46, 8'd45, 8'd44, 8'd43, 8'd42, 8'd41, 8'd40, 8'd99,
      8'd98, 8'd13, 8'd14, 8'd15, 8'd16, 8'd17, 8'd18, 8'd79, 8'd110,
      8'd54, 8'd53, 8'd52, 8'd51, 8'd50, 8'd49, 8'd48, 8'd130, 8'd130,
      8'd97, 8'd19, 8'd20, 8'd21, 8'd22, 8'd23, 8'd24, 8'd25, 8'd80,
      8'd111, 8'd60, 8'd59, 8'd58, 8'd57, 8'd56, 8'd55, 8'd129, 8'd129,
      8'd96, 8'd26, 8'd27, 8'd28, 8'd29, 8'd30, 8'd31, 8'd32, 8'd81,
      8'd112, 8'd68, 8'd67, 8'd66, 8'd65, 8'd64, 8'd63, 8'd62, 8'd61,
      8'd95, 8'd94, 8'd93, 8'd92, 8'd86, 8'd85, 8'd84, 8'd83, 8'd82,
      8'd113, 8'd114, 8'd115, 8'd123, 8'd124, 8'd125, 8'd126, 8'd127, 8'd128,
      8'd91, 8'd90, 8'd89, 8'd88, 8'd87, 8'd86, 8'd85, 8'd84, 8'd83,
      8'd114, 8'd115, 8'd116, 8'd117, 8'd118, 8'd119, 8'd120, 8'd121, 8'd122
   };

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] key;
      logic [3:0] col;
      logic [3:0] row;
      logic [7:0] cell_req;
      logic       odd;
   } grid_cmd_type;

   typedef struct {
      grid_cmd_type         c;
      bit                   fixed_want;
      wrg_pkg::shade_type   want;
   } directed_row_type;

   // directed sequence; typed-in shades only for reads of an empty cell or one just set by a key or drop
   directed_row_type directed_rows [25] = '{
      '{'{wrg_pkg::CMD_READ, 8'd0, 4'd0, 4'd0, 8'd0, 1'b0}, 1'b1,
        '{8'd0, 8'd255, 8'd0, 8'sd0}},
      '{'{wrg_pkg::CMD_READ, 8'd255, 4'd15, 4'd15, 8'd143, 1'b1}, 1'b1,
        '{8'd0, 8'd255, 8'd0, 8'sd0}},
      '{'{wrg_pkg::CMD_READ, 8'd0, 4'd0, 4'd0, 8'd144, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_READ, 8'd0, 4'd0, 4'd0, 8'd255, 1'b1}, 1'b0, '0},
      '{'{wrg_pkg::CMD_KEY, 8'd0, 4'd0, 4'd0, 8'd0, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_READ, 8'd0, 4'd0, 4'd0, 8'd71, 1'b0}, 1'b1,
        '{8'd190, 8'd1, 8'd255, 8'sd127}},
      '{'{wrg_pkg::CMD_KEY, 8'd143, 4'd0, 4'd0, 8'd0, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_KEY, 8'd144, 4'd0, 4'd0, 8'd0, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_KEY, 8'd255, 4'd0, 4'd0, 8'd0, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_DROP, 8'd0, 4'd0, 4'd0, 8'd0, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_DROP, 8'd0, 4'd15, 4'd8, 8'd0, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_DROP, 8'd0, 4'd7, 4'd9, 8'd0, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_DROP, 8'd0, 4'd15, 4'd15, 8'd0, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_READ, 8'd0, 4'd0, 4'd0, 8'd16, 1'b0}, 1'b1,
        '{8'd144, 8'd63, 8'd255, 8'sd96}},
      '{'{wrg_pkg::CMD_READ, 8'd0, 4'd0, 4'd0, 8'd142, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_TICK, 8'd0, 4'd0, 4'd0, 8'd0, 1'b1}, 1'b0, '0},
      '{'{wrg_pkg::CMD_TICK, 8'd0, 4'd0, 4'd0, 8'd0, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_READ, 8'd0, 4'd0, 4'd0, 8'd0, 1'b1}, 1'b0, '0},
      '{'{wrg_pkg::CMD_READ, 8'd0, 4'd0, 4'd0, 8'd127, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_DROP, 8'd0, 4'd8, 4'd4, 8'd0, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_TICK, 8'd0, 4'd0, 4'd0, 8'd0, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_READ, 8'd0, 4'd0, 4'd0, 8'd72, 1'b1}, 1'b0, '0},
      '{'{wrg_pkg::CMD_READ, 8'd0, 4'd0, 4'd0, 8'd143, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_TICK, 8'd0, 4'd0, 4'd0, 8'd0, 1'b0}, 1'b0, '0},
      '{'{wrg_pkg::CMD_READ, 8'd0, 4'd0, 4'd0, 8'd56, 1'b1}, 1'b0, '0}
   };

   logic                              clock;
   logic                              reset;
   logic                              req_valid;
   logic                              req_stall;
   logic [1:0]                        req_cmd;
   logic [7:0]                        req_key_address;
   logic [3:0]                        req_col;
   logic [3:0]                        req_row;
   logic [7:0]                        req_cell_req;
   logic                              req_odd_frame;
   logic                              rsp_valid;
   logic                              rsp_stall;
   logic [7:0]                        rsp_hue;
   logic [7:0]                        rsp_saturation;
   logic [7:0]                        rsp_brightness;
   logic signed [7:0]                 rsp_height;
   logic                              csr_valid;
   logic                              csr_ready;
   logic [wrg_pkg::CSR_IDX_W-1:0]     csr_index;
   logic [7:0]                        csr_wdata;

   // predictor state
   logic [7:0] level [2][NCELLS];
   bit         cur_pg;
   logic [7:0] hue_count;
   bit         rainbow_on;
   logic [7:0] steady_hue;

   wrg_pkg::shade_type pending_shades [$];
   int mismatch_count;
   int sender_idle_pct;
   int reader_stall_pct;

   water_ripple_grid DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_key_address (req_key_address),
      .req_col         (req_col),
      .req_row         (req_row),
      .req_cell_req    (req_cell_req),
      .req_odd_frame   (req_odd_frame),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_hue         (rsp_hue),
      .rsp_saturation  (rsp_saturation),
      .rsp_brightness  (rsp_brightness),
      .rsp_height      (rsp_height),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   initial begin
      #12_000_000;
      $display("end of test: mismatches");
      $finish;
   end

   function automatic int lvl(input bit pg, input int idx);
      return int'($signed(level[pg][idx]));
   endfunction

   // damped eight-neighbour step from the current page into the other one
   function automatic void ripple_step();
      int up, dn, lf, rt, sum, v, r, idx;
      bit nx;
      nx = ~cur_pg;
      for (int y = 0; y < ROWS; y++) begin
         up = (y == 0) ? y : y - 1;
         dn = (y == ROWS - 1) ? y : y + 1;
         for (int x = 0; x < COLS; x++) begin
            lf = (x == 0) ? x : x - 1;
            rt = (x == COLS - 1) ? x : x + 1;
            sum = lvl(cur_pg, up * COLS + x) + lvl(cur_pg, dn * COLS + x)
                + lvl(cur_pg, y * COLS + lf) + lvl(cur_pg, y * COLS + rt)
                + lvl(cur_pg, up * COLS + lf) + lvl(cur_pg, up * COLS + rt)
                + lvl(cur_pg, dn * COLS + lf) + lvl(cur_pg, dn * COLS + rt);
            idx = y * COLS + x;
            v = (sum >>> 2) - lvl(nx, idx);
            r = v - (v >>> 3);
            level[nx][idx] = r[7:0];
         end
      end
   endfunction

   // apply one command to the mirrored grid; returns 1 when a shade comes out
   function automatic bit grid_step(input grid_cmd_type c, output wrg_pkg::shade_type s,
                                    output bit acted);
      int h, mag, spot;
      logic [7:0] inten;
      s = '0;
      acted = 1'b0;
      case (c.cmd)
         wrg_pkg::CMD_KEY: begin
            if (c.key < NKEYS && KEY_CELL[c.key] < NCELLS) begin
               level[cur_pg][KEY_CELL[c.key]] = PEAK;
               acted = 1'b1;
            end
         end
         wrg_pkg::CMD_DROP: begin
            if (c.col < COLS && c.row < ROWS) begin
               spot = c.row * COLS + c.col;
               level[cur_pg][spot] = PEAK;
               if (c.row > 0) level[cur_pg][spot - COLS] = SPLASH;
               if (c.row < ROWS - 1) level[cur_pg][spot + COLS] = SPLASH;
               if (c.col > 0) level[cur_pg][spot - 1] = SPLASH;
               if (c.col < COLS - 1) level[cur_pg][spot + 1] = SPLASH;
               acted = 1'b1;
            end
         end
         wrg_pkg::CMD_TICK: begin
            hue_count = hue_count + 8'd1;
            acted = 1'b1;
            if (!c.odd) begin
               ripple_step();
               cur_pg = ~cur_pg;
            end
         end
         default: begin
            if (c.cell_req < NCELLS) begin
               acted = 1'b1;
               h = lvl(cur_pg, c.cell_req);
               if (c.odd) h = (h + lvl(~cur_pg, c.cell_req)) >>> 1;
               mag = (h < 0) ? -h : h;
               inten = 8'(mag * 2);
               s.saturation = 8'hff - inten;
               s.brightness = (inten >= 8'd128) ? 8'hff : {inten[6:0], 1'b0};
               s.hue = rainbow_on ? 8'(int'(hue_count) + h + (h >>> 1)) : steady_hue;
               s.height = h[7:0];
               return 1'b1;
            end
         end
      endcase
      return 1'b0;
   endfunction

   // mostly in-range commands with random content, some off-grid ones
   function automatic grid_cmd_type random_cmd();
      grid_cmd_type c;
      int pick;
      c.key  = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(143));
      c.col  = 4'($urandom_range(15));
      c.row  = ($urandom_range(9) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(8));
      c.cell_req = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                            : 8'($urandom_range(143));
      c.odd  = 1'($urandom_range(1));
      pick = $urandom_range(99);
      if (pick < 45)      c.cmd = wrg_pkg::CMD_READ;
      else if (pick < 67) c.cmd = wrg_pkg::CMD_KEY;
      else if (pick < 89) c.cmd = wrg_pkg::CMD_DROP;
      else                c.cmd = wrg_pkg::CMD_TICK;
      return c;
   endfunction

   // one request transfer; starts and ends on a falling edge
   task automatic send_cmd(input grid_cmd_type c, input bit fixed_want,
                           input wrg_pkg::shade_type want, output bit acted);
      wrg_pkg::shade_type s;
      while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_cmd         <= c.cmd;
      req_key_address <= c.key;
      req_col         <= c.col;
      req_row         <= c.row;
      req_cell_req    <= c.cell_req;
      req_odd_frame   <= c.odd;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (grid_step(c, s, acted)) pending_shades.push_back(fixed_want ? want : s);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [wrg_pkg::CSR_IDX_W-1:0] idx, input logic [7:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      if (idx == wrg_pkg::CSR_RAINBOW_MODE) rainbow_on = data[0];
      else steady_hue = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait out every expected shade and any frame step still walking the grid
   task automatic settle();
      while (pending_shades.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver stalls
   always @(negedge clock) begin
      rsp_stall <= (reader_stall_pct != 0) && ($urandom_range(99) < reader_stall_pct);
   end

   // compare every result transfer against the oldest expected shade
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_shades.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected shade: hue %0d sat %0d bright %0d height %0d",
                        rsp_hue, rsp_saturation, rsp_brightness, rsp_height);
         end else begin
            if (rsp_hue !== pending_shades[0].hue
                || rsp_saturation !== pending_shades[0].saturation
                || rsp_brightness !== pending_shades[0].brightness
                || rsp_height !== pending_shades[0].height) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("shade mismatch: want %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                           pending_shades[0].hue, pending_shades[0].saturation,
                           pending_shades[0].brightness, $signed(pending_shades[0].height),
                           rsp_hue, rsp_saturation, rsp_brightness, rsp_height);
            end
            void'(pending_shades.pop_front());
         end
      end
   end

   // stimulus
   initial begin
      int done_items;
      bit acted;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_cmd         = wrg_pkg::CMD_KEY;
      req_key_address = '0;
      req_col         = '0;
      req_row         = '0;
      req_cell_req    = '0;
      req_odd_frame   = 1'b0;
      rsp_stall       = 1'b0;
      csr_valid       = 1'b0;
      csr_index       = wrg_pkg::CSR_RAINBOW_MODE;
      csr_wdata       = '0;
      mismatch_count  = 0;
      sender_idle_pct = 0;
      reader_stall_pct = 0;
      for (int i = 0; i < NCELLS; i++) begin
         level[0][i] = '0;
         level[1][i] = '0;
      end
      cur_pg     = 1'b0;
      hue_count  = '0;
      rainbow_on = 1'b1;
      steady_hue = '0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed sequence at reset settings
      foreach (directed_rows[i])
         send_cmd(directed_rows[i].c, directed_rows[i].fixed_want, directed_rows[i].want,
                  acted);
      req_valid <= 1'b0;

      // random phases, each under its own register setting and idling mix
      for (int phase = 0; phase < 4; phase++) begin
         settle();
         case (phase)
            0: begin
               write_reg(wrg_pkg::CSR_RAINBOW_MODE, 8'd1);
               write_reg(wrg_pkg::CSR_FIXED_HUE, 8'd255);
               sender_idle_pct = 0;
               reader_stall_pct = 0;
            end
            1: begin
               write_reg(wrg_pkg::CSR_RAINBOW_MODE, 8'd0);
               sender_idle_pct = 81;
               reader_stall_pct = 0;
            end
            2: begin
               write_reg(wrg_pkg::CSR_FIXED_HUE, 8'd0);
               sender_idle_pct = 0;
               reader_stall_pct = 81;
            end
            default: begin
               write_reg(wrg_pkg::CSR_RAINBOW_MODE, 8'd1);
               write_reg(wrg_pkg::CSR_FIXED_HUE, 8'($urandom_range(254, 1)));
               sender_idle_pct = 19;
               reader_stall_pct = 19;
            end
         endcase
         done_items = 0;
         while (done_items < ITEMS_PER_PHASE) begin
            send_cmd(random_cmd(), 1'b0, '0, acted);
            if (acted) done_items++;
         end
         req_valid <= 1'b0;
      end

      // drain and report
      settle();
      if (mismatch_count == 0 && pending_shades.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/wrg_pkg.sv
sv/wrg_ram.sv
sv/wrg_ripple.sv
sv/wrg_shade.sv
sv/water_ripple_grid.sv
tb/tb_water_ripple_grid.sv
